// ===== sv/usrm_pkg.sv =====
// shared types and constants of the ultrasonic ranger with median filter
// no dependencies; compile first
`default_nettype none
package usrm_pkg;

	localparam int WINDOW_DEF   = 5;
	localparam int CHANNELS_DEF = 4;
	localparam int QUEUE_DEPTH  = 4;

	localparam int NOW_W  = 32;
	localparam int DIV_W  = 16;
	localparam int RAW_W  = 10;
	localparam int DIST_W = 14;

	localparam logic [NOW_W-1:0]  ACCEPT_LIMIT = 32'd1000;
	localparam logic [DIST_W-1:0] FAR_VALUE    = 14'd10000;

	// register map, index into the byte address bits [3:2]
	localparam logic [1:0] REG_US_PER_CM    = 2'd0;
	localparam logic [1:0] REG_WAIT_LOW_US  = 2'd1;
	localparam logic [1:0] REG_WAIT_HIGH_US = 2'd2;

	localparam logic [31:0] US_PER_CM_RST = 32'd58;
	localparam logic [31:0] WAIT_RST      = 32'd30000;

	// one measurement handed from front to back
	typedef struct packed {
		logic [1:0]       ch;
		logic [NOW_W-1:0] elapsed;
		logic             last;
	} job_t;

	// queue control between front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

// ===== sv/usrm_if.sv =====
// valid/ready channel interfaces for input items and result items
// no dependencies
`default_nettype none
interface usrm_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [1:0]  channel;
	logic [31:0] now_us;

	modport source (output valid, opcode, channel, now_us, input ready);
	modport sink   (input valid, opcode, channel, now_us, output ready);
endinterface

interface usrm_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  channel_out;
	logic        sample_accepted;
	logic [9:0]  raw_distance;
	logic [13:0] filtered_distance;
	logic        last;

	modport source (output valid, channel_out, sample_accepted, raw_distance,
		filtered_distance, last, input ready);
	modport sink   (input valid, channel_out, sample_accepted, raw_distance,
		filtered_distance, last, output ready);
endinterface
`default_nettype wire

// ===== sv/usrm_front.sv =====
// front part: takes items, tracks channel phases and start times, posts jobs
// depends on usrm_pkg and usrm_if
`default_nettype none
module usrm_front import usrm_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	usrm_in_if.sink           in_ch,
	input  wire logic [31:0]  wait_low_us,
	input  wire logic [31:0]  wait_high_us,
	input  wire q_status_t    q_stat,
	output logic              push,
	output job_t              push_job
);

	localparam int ACTIVE = (CHANNELS < 4) ? CHANNELS : 4;
	localparam int CIW    = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
	localparam logic [2:0] ACTIVE_L = 3'(ACTIVE);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_EMIT = 2'b10
	} fstate_t;

	fstate_t            state_q;
	logic               phase_q [ACTIVE];
	logic [NOW_W-1:0]   start_q [ACTIVE];
	logic [NOW_W-1:0]   el_q    [ACTIVE];
	logic [ACTIVE-1:0]  mask_q;

	logic [NOW_W-1:0]   elapsed [ACTIVE];
	logic [ACTIVE-1:0]  tmo;
	logic               accept;
	logic               echo_ok;
	logic [CIW-1:0]     ech;
	logic [CIW-1:0]     sel;
	logic [ACTIVE-1:0]  sel_oh;
	logic [ACTIVE-1:0]  rest;

	// elapsed time and timeout test for every channel
	always_comb begin
		for (int c = 0; c < ACTIVE; c++) begin
			elapsed[c] = in_ch.now_us - start_q[c];
			tmo[c] = phase_q[c] ? (elapsed[c] > wait_high_us) : (elapsed[c] > wait_low_us);
		end
	end

	assign in_ch.ready = (state_q == F_IDLE) && !q_stat.full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign echo_ok     = ({1'b0, in_ch.channel} < ACTIVE_L);
	assign ech         = in_ch.channel[CIW-1:0];

	// lowest pending timed-out channel
	always_comb begin
		sel    = '0;
		sel_oh = '0;
		for (int c = ACTIVE - 1; c >= 0; c--) begin
			if (mask_q[c]) begin
				sel    = CIW'(c);
				sel_oh = ACTIVE'(1) << c;
			end
		end
		rest = mask_q & ~sel_oh;
	end

	// job posting
	always_comb begin
		push     = 1'b0;
		push_job = '0;
		if (accept && in_ch.opcode && echo_ok && phase_q[ech]) begin
			push             = 1'b1;
			push_job.ch      = in_ch.channel;
			push_job.elapsed = elapsed[ech];
			push_job.last    = 1'b1;
		end else if ((state_q == F_EMIT) && !q_stat.full) begin
			push             = 1'b1;
			push_job.ch      = 2'(sel);
			push_job.elapsed = el_q[sel];
			push_job.last    = (rest == '0);
		end
	end

	// phase, start time and emit sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			mask_q  <= '0;
			for (int c = 0; c < ACTIVE; c++) begin
				phase_q[c] <= 1'b1;
				start_q[c] <= '0;
			end
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						if (in_ch.opcode) begin
							if (echo_ok) begin
								start_q[ech] <= in_ch.now_us;
								phase_q[ech] <= !phase_q[ech];
							end
						end else begin
							for (int c = 0; c < ACTIVE; c++) begin
								if (tmo[c]) begin
									start_q[c] <= in_ch.now_us;
									phase_q[c] <= 1'b0;
								end
							end
							mask_q <= tmo;
							if (|tmo) state_q <= F_EMIT;
						end
					end
				end
				F_EMIT: begin
					if (!q_stat.full) begin
						mask_q <= rest;
						if (rest == '0) state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// elapsed times captured by a poll
	always_ff @(posedge clk) begin
		if (accept && !in_ch.opcode) begin
			for (int c = 0; c < ACTIVE; c++) el_q[c] <= elapsed[c];
		end
	end

endmodule
`default_nettype wire

// ===== sv/usrm_queue.sv =====
// short job queue between front and back
// depends on usrm_pkg
`default_nettype none
module usrm_queue import usrm_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire job_t      push_job,
	input  wire logic      pop,
	output job_t           head,
	output q_status_t      q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign q_stat.full  = (cnt_q == (PW+1)'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_job;
	end

endmodule
`default_nettype wire

// ===== sv/usrm_back.sv =====
// back part: serial divide, window update, median search, result register
// depends on usrm_pkg and usrm_if
`default_nettype none
module usrm_back import usrm_pkg::*; #(
	parameter int WINDOW   = WINDOW_DEF,
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire job_t              head,
	input  wire q_status_t         q_stat,
	output logic                   pop,
	input  wire logic [DIV_W-1:0]  us_per_cm,
	usrm_out_if.source             out_ch
);

	localparam int ACTIVE = (CHANNELS < 4) ? CHANNELS : 4;
	localparam int CIW    = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
	localparam int WIDX   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int RW     = $clog2(WINDOW + 1);
	localparam logic [RW-1:0] MID = RW'(WINDOW / 2);

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_DIV  = 4'b0010,
		B_MED  = 4'b0100,
		B_OUT  = 4'b1000
	} bstate_t;

	bstate_t           state_q;
	logic [1:0]        ch_q;
	logic              last_q;
	logic              acc_q;
	logic [RAW_W-1:0]  raw_q;
	logic [DIST_W-1:0] filt_q;
	logic [NOW_W-1:0]  dvd_q;
	logic [NOW_W-1:0]  quot_q;
	logic [DIV_W-1:0]  rem_q;
	logic [4:0]        cnt_q;
	logic [WIDX-1:0]   midx_q;
	logic [DIST_W-1:0] win_q [ACTIVE][WINDOW];
	logic [WIDX-1:0]   pos_q [ACTIVE];
	logic [DIST_W-1:0] med_q [ACTIVE];

	logic [CIW-1:0]    bch;
	logic [DIV_W:0]    sh;
	logic              ge;
	logic [DIV_W-1:0]  rem_n;
	logic [NOW_W-1:0]  quot_n;
	logic [DIST_W-1:0] cand;
	logic [RW-1:0]     rank;

	assign bch = ch_q[CIW-1:0];
	assign pop = (state_q == B_IDLE) && !q_stat.empty;

	// one restoring divide step
	always_comb begin
		sh     = {rem_q, dvd_q[NOW_W-1]};
		ge     = (sh >= {1'b0, us_per_cm});
		rem_n  = ge ? DIV_W'(sh - {1'b0, us_per_cm}) : sh[DIV_W-1:0];
		quot_n = {quot_q[NOW_W-2:0], ge};
	end

	// stable rank of one window entry
	always_comb begin
		cand = win_q[bch][midx_q];
		rank = '0;
		for (int j = 0; j < WINDOW; j++) begin
			if ((win_q[bch][j] < cand) ||
				((win_q[bch][j] == cand) && (WIDX'(j) < midx_q)))
				rank = rank + 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ch_q    <= '0;
			last_q  <= 1'b0;
			acc_q   <= 1'b0;
			raw_q   <= '0;
			filt_q  <= '0;
			dvd_q   <= '0;
			quot_q  <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			midx_q  <= '0;
			for (int c = 0; c < ACTIVE; c++) begin
				pos_q[c] <= '0;
				med_q[c] <= FAR_VALUE;
				for (int k = 0; k < WINDOW; k++) win_q[c][k] <= FAR_VALUE;
			end
		end else begin
			case (state_q)
				B_IDLE: begin
					if (!q_stat.empty) begin
						ch_q    <= head.ch;
						last_q  <= head.last;
						dvd_q   <= head.elapsed;
						quot_q  <= '0;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					rem_q  <= rem_n;
					quot_q <= quot_n;
					dvd_q  <= {dvd_q[NOW_W-2:0], 1'b0};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == 5'd31) begin
						if (quot_n < ACCEPT_LIMIT) begin
							win_q[bch][pos_q[bch]] <= quot_n[DIST_W-1:0];
							pos_q[bch] <= (pos_q[bch] == WIDX'(WINDOW - 1)) ? '0
								: pos_q[bch] + 1'b1;
							acc_q   <= 1'b1;
							raw_q   <= quot_n[RAW_W-1:0];
							midx_q  <= '0;
							state_q <= B_MED;
						end else begin
							acc_q   <= 1'b0;
							raw_q   <= '0;
							filt_q  <= med_q[bch];
							state_q <= B_OUT;
						end
					end
				end
				B_MED: begin
					if (rank == MID) begin
						med_q[bch] <= cand;
						filt_q     <= cand;
						state_q    <= B_OUT;
					end else begin
						midx_q <= midx_q + 1'b1;
					end
				end
				B_OUT: begin
					if (out_ch.ready) state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// result register
	assign out_ch.valid             = (state_q == B_OUT);
	assign out_ch.channel_out       = ch_q;
	assign out_ch.sample_accepted   = acc_q;
	assign out_ch.raw_distance      = raw_q;
	assign out_ch.filtered_distance = filt_q;
	assign out_ch.last              = last_q;

endmodule
`default_nettype wire

// ===== sv/ultrasonic_ranger_median.sv =====
// Four-channel ultrasonic range controller with a median filter per channel.
// in_ch carries an echo pin change (opcode 1) on one channel, or a timeout
// poll (opcode 0) of all channels, each with the current microsecond time.
// out_ch carries one transfer per completed measurement; last marks the
// final result caused by an input item. An echo that starts a measurement
// and a poll with no timeout cause no result.
// The front tracks phases and start times and takes an item per cycle while
// its four-entry job queue has room and it is not posting a poll's jobs; a
// poll stays in the front until it has posted one job per timed-out channel.
// The back works one job at a time: it takes the job, runs its
// one-bit-per-cycle divider, then, for an accepted sample, the median search
// over the channel window, then holds the result register.
// While out_ch is stalled the result holds, the back waits, and the front
// keeps taking items until the queue is full.
// Reset restores the register defaults, puts every channel in the measuring
// phase with start time zero, and fills every window with 10000.
// APB registers: 0x0 us_per_cm, 0x4 wait_low_us, 0x8 wait_high_us.
// depends on usrm_pkg, usrm_if, usrm_front, usrm_queue, usrm_back
`default_nettype none
module ultrasonic_ranger_median import usrm_pkg::*; #(
	parameter int WINDOW   = WINDOW_DEF,
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	usrm_in_if.sink          in_ch,
	usrm_out_if.source       out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [DIV_W-1:0] us_per_cm_q;
	logic [31:0]      wait_low_q;
	logic [31:0]      wait_high_q;
	logic             cfg_wr;
	logic             push;
	logic             pop;
	job_t             push_job;
	job_t             head;
	q_status_t        q_stat;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			us_per_cm_q <= US_PER_CM_RST[DIV_W-1:0];
			wait_low_q  <= WAIT_RST;
			wait_high_q <= WAIT_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_US_PER_CM:    us_per_cm_q <= pwdata[DIV_W-1:0];
				REG_WAIT_LOW_US:  wait_low_q  <= pwdata;
				REG_WAIT_HIGH_US: wait_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[3:2])
			REG_US_PER_CM:    prdata = {16'd0, us_per_cm_q};
			REG_WAIT_LOW_US:  prdata = wait_low_q;
			REG_WAIT_HIGH_US: prdata = wait_high_q;
			default:          prdata = '0;
		endcase
	end

	usrm_front #(.CHANNELS(CHANNELS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.wait_low_us  (wait_low_q),
		.wait_high_us (wait_high_q),
		.q_stat       (q_stat),
		.push         (push),
		.push_job     (push_job)
	);

	usrm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	usrm_back #(.WINDOW(WINDOW), .CHANNELS(CHANNELS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.us_per_cm (us_per_cm_q),
		.out_ch    (out_ch)
	);

	// a job is never posted into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full) else $error("job posted into full queue");

	// the back only takes jobs that exist
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty) else $error("pop from empty queue");

	// a rejected sample reports zero distance
	a_raw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.sample_accepted) |-> (out_ch.raw_distance == '0))
		else $error("raw distance on rejected sample");

	// filtered distance never exceeds the far value
	a_filt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.filtered_distance <= FAR_VALUE))
		else $error("filtered distance out of range");

endmodule
`default_nettype wire

// ===== tb/usrm_range_checker.sv =====
// result checker for the ultrasonic ranger: mirrors channel phases, windows and medians
// depends on usrm_pkg and usrm_if; the top forwards every register write
`timescale 1ns / 1ps
`default_nettype none
module usrm_range_checker import usrm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	usrm_in_if         in_ch,
	usrm_out_if        out_ch,
	input  wire logic        reg_we,
	input  wire logic [1:0]  reg_idx,
	input  wire logic [31:0] reg_val,
	output int         fail_count,
	output int         pending
);
	localparam int WIN = WINDOW_DEF;
	localparam int NCH = 4;

	typedef struct packed {
		logic [1:0]        ch;
		logic              acc;
		logic [RAW_W-1:0]  raw;
		logic [DIST_W-1:0] med;
		logic              last;
	} range_res_t;

	logic [DIV_W-1:0]  div_cm;
	logic [31:0]       lim_low, lim_high;
	logic              measuring [NCH];
	logic [31:0]       t_start [NCH];
	int                wpos [NCH];
	logic [DIST_W-1:0] wstore [NCH][WIN];
	logic [DIST_W-1:0] med_val [NCH];
	range_res_t        expected_q [$];

	assign pending = expected_q.size();

	function automatic logic [DIST_W-1:0] median_of(int c);
		logic [DIST_W-1:0] t [WIN];
		logic [DIST_W-1:0] v;
		for (int i = 0; i < WIN; i++) t[i] = wstore[c][i];
		for (int i = 1; i < WIN; i++)
			for (int j = i; j > 0; j--)
				if (t[j-1] > t[j]) begin
					v = t[j]; t[j] = t[j-1]; t[j-1] = v;
				end
		return t[WIN/2];
	endfunction

	// finish one measurement and queue its result
	task automatic finish_range(int c, logic [31:0] now);
		logic [31:0] el, d;
		range_res_t r;
		el = now - t_start[c];
		d = (div_cm == 0) ? 32'hFFFF_FFFF : el / div_cm;
		r = '0;
		r.ch = 2'(c);
		if (d < ACCEPT_LIMIT) begin
			wstore[c][wpos[c]] = d[DIST_W-1:0];
			wpos[c] = (wpos[c] == WIN-1) ? 0 : wpos[c] + 1;
			med_val[c] = median_of(c);
			r.acc = 1'b1;
			r.raw = d[RAW_W-1:0];
		end
		r.med = med_val[c];
		t_start[c] = now;
		measuring[c] = 1'b0;
		expected_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		int n0;
		range_res_t got, exp_r;
		logic [31:0] el;
		logic to;
		if (!arst_n) begin
			div_cm <= US_PER_CM_RST[DIV_W-1:0];
			lim_low <= WAIT_RST;
			lim_high <= WAIT_RST;
			for (int c = 0; c < NCH; c++) begin
				measuring[c] = 1'b1;
				t_start[c] = '0;
				wpos[c] = 0;
				med_val[c] = FAR_VALUE;
				for (int k = 0; k < WIN; k++) wstore[c][k] = FAR_VALUE;
			end
			expected_q.delete();
			fail_count <= 0;
		end else begin
			// register writes
			if (reg_we) begin
				case (reg_idx)
					REG_US_PER_CM: div_cm <= reg_val[DIV_W-1:0];
					REG_WAIT_LOW_US: lim_low <= reg_val;
					REG_WAIT_HIGH_US: lim_high <= reg_val;
					default: ;
				endcase
			end
			// result transfer compared before the new input is predicted
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.channel_out, out_ch.sample_accepted, out_ch.raw_distance,
					out_ch.filtered_distance, out_ch.last};
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, got);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch, expected ch%0d acc%0d raw%0d med%0d last%0d,",
							$time, exp_r.ch, exp_r.acc, exp_r.raw, exp_r.med, exp_r.last,
							" actual ch%0d acc%0d raw%0d med%0d last%0d",
							got.ch, got.acc, got.raw, got.med, got.last);
						fail_count <= fail_count + 1;
					end
				end
			end
			// input transfer
			if (in_ch.valid && in_ch.ready) begin
				n0 = expected_q.size();
				if (in_ch.opcode) begin
					if (measuring[in_ch.channel])
						finish_range(in_ch.channel, in_ch.now_us);
					else begin
						t_start[in_ch.channel] = in_ch.now_us;
						measuring[in_ch.channel] = 1'b1;
					end
				end else begin
					for (int c = 0; c < NCH; c++) begin
						el = in_ch.now_us - t_start[c];
						to = measuring[c] ? (el > lim_high) : (el > lim_low);
						if (to) finish_range(c, in_ch.now_us);
					end
				end
				if (expected_q.size() > n0)
					expected_q[expected_q.size()-1].last = 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== tb/ultrasonic_ranger_median_tb.sv =====
// stimulus and verdict for the ultrasonic ranger with median filter
// depends on usrm_pkg, usrm_if, usrm_range_checker and the block itself
`timescale 1ns / 1ps
`default_nettype none
module ultrasonic_ranger_median_tb;
	import usrm_pkg::*;

	localparam logic OP_POLL = 1'b0;
	localparam logic OP_ECHO = 1'b1;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	int fail_count, pending;
	int idle_cycles = 0;
	bit hold_long = 1'b0;
	bit sending_done = 1'b0;
	logic [31:0] clock_us = '0;

	usrm_in_if in_ch ();
	usrm_out_if out_ch ();

	ultrasonic_ranger_median dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready));

	usrm_range_checker chk (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.reg_we(psel && penable && pwrite && pready), .reg_idx(paddr[3:2]),
		.reg_val(pwdata), .fail_count(fail_count), .pending(pending));

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_POLL;
		in_ch.channel = '0;
		in_ch.now_us = '0;
		out_ch.ready = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// result side: random stalls, plus one long hold-off
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_ch.ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_long = 1'b0;
			end
			g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (g > 0) begin
				out_ch.ready <= 1'b0;
				repeat (g - 1) @(posedge clk);
			end else
				out_ch.ready <= 1'b1;
		end
	end

	// watchdog on transfers
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else if (!(sending_done && pending == 0))
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// one input transfer; valid is held across back-to-back items
	task automatic send_item(logic op, logic [1:0] ch, logic [31:0] now);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.channel <= ch;
		in_ch.now_us <= now;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// an echo pair of a given duration on a channel
	task automatic echo_pair(logic [1:0] ch, logic [31:0] dur);
		clock_us = clock_us + $urandom_range(1, 50);
		send_item(OP_ECHO, ch, clock_us);
		clock_us = clock_us + dur;
		send_item(OP_ECHO, ch, clock_us);
	endtask

	initial begin
		int sel;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: echo ends from reset, measuring phase
		send_item(OP_ECHO, 2'd0, 32'd0);
		send_item(OP_ECHO, 2'd1, 32'd57999);
		send_item(OP_ECHO, 2'd2, 32'd58000);
		send_item(OP_ECHO, 2'd3, 32'hFFFF_FFFF);
		// start then end, with wrapped time
		send_item(OP_ECHO, 2'd0, 32'hFFFF_FF00);
		send_item(OP_ECHO, 2'd0, 32'd5000);
		// polls that time out some channels, then all channels twice
		send_item(OP_POLL, 2'd3, 32'd5000);
		send_item(OP_POLL, 2'd1, 32'h8000_0000);
		send_item(OP_POLL, 2'd2, 32'h8000_7531);
		drain();

		// zero divisor and zero timeouts
		reg_write(REG_US_PER_CM, 32'd0);
		reg_write(REG_WAIT_LOW_US, 32'd0);
		reg_write(REG_WAIT_HIGH_US, 32'd0);
		send_item(OP_POLL, 2'd0, 32'h8000_7532);
		send_item(OP_ECHO, 2'd1, 32'h8000_7600);
		send_item(OP_ECHO, 2'd1, 32'h8000_7700);
		drain();

		// maximal divisor and timeouts
		reg_write(REG_US_PER_CM, 32'd65535);
		reg_write(REG_WAIT_LOW_US, 32'hFFFF_FFFF);
		reg_write(REG_WAIT_HIGH_US, 32'hFFFF_FFFF);
		send_item(OP_ECHO, 2'd2, 32'h0);
		send_item(OP_ECHO, 2'd2, 32'hFFFF_FFFF);
		send_item(OP_POLL, 2'd0, 32'h1234_5678);
		drain();

		// random phases under several settings
		for (int ph = 0; ph < 4; ph++) begin
			reg_write(REG_US_PER_CM, (ph == 3) ? 32'd1 : $urandom_range(1, 80));
			reg_write(REG_WAIT_LOW_US, $urandom_range(0, 40000));
			reg_write(REG_WAIT_HIGH_US, (ph == 0) ? 32'd0 : $urandom_range(500, 60000));
			if (ph == 1) hold_long = 1'b1;
			for (int i = 0; i < 45; i++) begin
				sel = $urandom_range(0, 99);
				if (sel < 65) begin
					echo_pair(2'($urandom), $urandom_range(0, 70000));
					i++;
				end else if (sel < 85) begin
					clock_us = clock_us + $urandom_range(0, 80000);
					send_item(OP_POLL, 2'($urandom), clock_us);
				end else
					send_item(1'($urandom), 2'($urandom), $urandom);
			end
			drain();
		end
		sending_done = 1'b1;

		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire

// ===== ultrasonic_ranger_median.f =====
sv/usrm_pkg.sv
sv/usrm_if.sv
sv/usrm_front.sv
sv/usrm_queue.sv
sv/usrm_back.sv
sv/ultrasonic_ranger_median.sv
tb/usrm_range_checker.sv
tb/ultrasonic_ranger_median_tb.sv
